[rtl/core/mqm_pkg.sv]
// ----------------------------------------------------------------------------
// mqm_pkg
// Shared types and constants for the monotonic minimum queue: request and
// response beats, request and error codes, and the links between cells.
// ----------------------------------------------------------------------------
package mqm_pkg;

    localparam int DEPTH   = 1024;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef logic [COUNT_W-1:0] t_count;

    // request codes
    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEQ = 2'd1,
        REQ_CLR = 2'd2,
        REQ_QRY = 2'd3
    } t_req_type;

    // error codes
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // control sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // input beat
    typedef struct packed {
        t_req_type                req_type;
        logic signed [DATA_W-1:0] data_in;
    } t_req;

    // output beat
    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] min_value;
        t_count                   count;
        logic                     is_empty;
        t_err                     err_code;
    } t_rsp;

    // operation broadcast to every cell
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic                     cand_pop;
        logic                     clr;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

    // cell contents, shifted toward the head on a pop
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] cand;
        logic                     valid;
    } t_shift;

    // candidate status seen by the next cell toward the back
    typedef struct packed {
        logic valid;
        logic gt;
    } t_link;

endpackage

[rtl/core/mqm_cell.sv]
// ----------------------------------------------------------------------------
// mqm_cell
// One slot of the queue: holds one value entry and one candidate entry,
// takes new contents from the neighbor behind it on a pop and decides on
// its own whether it receives an appended candidate.
// ----------------------------------------------------------------------------
module mqm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mqm_pkg::t_cell_ctl i_ctl,
    input  logic               i_val_wr,
    input  mqm_pkg::t_link     i_left,
    input  mqm_pkg::t_shift    i_right,
    output mqm_pkg::t_shift    o_shift,
    output mqm_pkg::t_link     o_link
);

    logic signed [mqm_pkg::DATA_W-1:0] r_value, n_value;
    logic signed [mqm_pkg::DATA_W-1:0] r_cand, n_cand;
    logic                              r_cvalid, n_cvalid;
    logic                              gt;
    logic                              take;

    // candidate strictly above the incoming value
    assign gt = r_cvalid && (r_cand > i_ctl.data);

    // first free or dropped slot right after the kept candidates
    assign take = (!r_cvalid || gt) && i_left.valid && !i_left.gt;

    // next contents
    always_comb begin
        n_value  = r_value;
        n_cand   = r_cand;
        n_cvalid = r_cvalid;
        if (i_ctl.clr) begin
            n_cvalid = 1'b0;
        end else if (i_ctl.enq) begin
            if (i_val_wr) begin
                n_value = i_ctl.data;
            end
            if (take) begin
                n_cand   = i_ctl.data;
                n_cvalid = 1'b1;
            end else if (gt) begin
                n_cvalid = 1'b0;
            end
        end else if (i_ctl.deq) begin
            n_value = i_right.value;
            if (i_ctl.cand_pop) begin
                n_cand   = i_right.cand;
                n_cvalid = i_right.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_cand  <= n_cand;
    end

    // candidate valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= 1'b0;
        end else begin
            r_cvalid <= n_cvalid;
        end
    end

    assign o_shift.value = r_value;
    assign o_shift.cand  = r_cand;
    assign o_shift.valid = r_cvalid;
    assign o_link.valid  = r_cvalid;
    assign o_link.gt     = gt;

endmodule

[rtl/core/min_queue_monotonic.sv]
// ----------------------------------------------------------------------------
// min_queue_monotonic
// FIFO of signed values that reports its minimum, built as a row of cells.
// Each cell holds one FIFO entry and one entry of the monotonic candidate
// deque; the head of both sits in cell 0.
//
//   channel  valid         ready         payload
//   input    i_in_valid    o_in_ready    i_in_data  (mqm_pkg::t_req)
//   output   o_out_valid   i_out_ready   o_out_data (mqm_pkg::t_rsp)
//
// For each request the cell row updates at the accept edge; ST_RESP then
// loads the result register from cell 0 and the count when it is free.
// Reset is synchronous; it clears the candidate valid bits, the count and
// the control state at once, with no clearing pass over the cells.
// While a result waits in the output register, one more request may be
// accepted; input ready then stays low until the result register is free.
// ----------------------------------------------------------------------------
module min_queue_monotonic #(
    parameter int DEPTH = mqm_pkg::DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mqm_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mqm_pkg::t_rsp o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    mqm_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic signed [mqm_pkg::DATA_W-1:0] r_popped, n_popped;
    mqm_pkg::t_err      r_err, n_err;
    logic               r_out_valid, n_out_valid;
    mqm_pkg::t_rsp      r_out, n_out;

    logic               accept;
    logic               full;
    logic               empty;
    mqm_pkg::t_cell_ctl ctl;

    mqm_pkg::t_shift    cell_shift [DEPTH];
    mqm_pkg::t_link     cell_link  [DEPTH];

    assign accept = i_in_valid && o_in_ready;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    // operation broadcast to the cell row
    always_comb begin
        ctl.data     = i_in_data.data_in;
        ctl.enq      = accept && (i_in_data.req_type == mqm_pkg::REQ_ENQ) && !full;
        ctl.deq      = accept && (i_in_data.req_type == mqm_pkg::REQ_DEQ) && !empty;
        ctl.clr      = accept && (i_in_data.req_type == mqm_pkg::REQ_CLR);
        ctl.cand_pop = cell_shift[0].valid && (cell_shift[0].cand == cell_shift[0].value);
    end

    // cell row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        mqm_pkg::t_link  left;
        mqm_pkg::t_shift right;

        if (gi == 0) begin : g_head
            assign left = '{valid: 1'b1, gt: 1'b0};
        end else begin : g_mid
            assign left = cell_link[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right = '{value: '0, cand: '0, valid: 1'b0};
        end else begin : g_body
            assign right = cell_shift[gi+1];
        end

        mqm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_val_wr (r_count == CW'(gi)),
            .i_left   (left),
            .i_right  (right),
            .o_shift  (cell_shift[gi]),
            .o_link   (cell_link[gi])
        );
    end

    // sequencer, count and result register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_popped    = r_popped;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_in_ready  = (r_state == mqm_pkg::ST_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mqm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_popped = '0;
                    n_err    = mqm_pkg::ERR_OK;
                    case (i_in_data.req_type)
                        mqm_pkg::REQ_ENQ: begin
                            if (full) begin
                                n_err = mqm_pkg::ERR_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        mqm_pkg::REQ_DEQ: begin
                            if (empty) begin
                                n_err = mqm_pkg::ERR_EMPTY;
                            end else begin
                                n_popped = cell_shift[0].value;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        mqm_pkg::REQ_CLR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_state = mqm_pkg::ST_RESP;
                end
            end
            mqm_pkg::ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.popped_value = r_popped;
                    n_out.front_value  = empty ? '0 : cell_shift[0].value;
                    n_out.min_value    = (!empty && cell_shift[0].valid) ?
                                         cell_shift[0].cand : '0;
                    n_out.count        = mqm_pkg::t_count'(r_count);
                    n_out.is_empty     = empty;
                    n_out.err_code     = r_err;
                    n_out_valid        = 1'b1;
                    n_state            = mqm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mqm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mqm_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_err    <= n_err;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/mqm_checker.sv]
// ----------------------------------------------------------------------------
// mqm_checker
// Port-level checks for the monotonic minimum queue, bound to the top level.
// ----------------------------------------------------------------------------
module mqm_checker #(
    parameter int DEPTH = mqm_pkg::DEPTH
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input mqm_pkg::t_rsp o_out_data
);

    // a waiting result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one request in flight: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted back to back");

    // empty flag agrees with count, and empty shows zero front and minimum
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.count == '0)) &&
        (!o_out_data.is_empty ||
         (o_out_data.front_value == '0 && o_out_data.min_value == '0)))
        else $error("empty result inconsistent");

    // a full error only at full count
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.err_code == mqm_pkg::ERR_FULL |->
        o_out_data.count == mqm_pkg::t_count'(DEPTH))
        else $error("full error below capacity");

    // minimum never above the front value
    a_min_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_empty |->
        o_out_data.min_value <= o_out_data.front_value)
        else $error("minimum above front value");

endmodule

bind min_queue_monotonic mqm_checker #(.DEPTH(DEPTH)) u_mqm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
